// File: rtl/decimal_string_to_int_validator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the decimal string parser
// Immediate-implication and next-cycle-implication checks on the clock clk,
// held off while rst is high.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_STRING_TO_INT_VALIDATOR_MACROS_SVH
`define DECIMAL_STRING_TO_INT_VALIDATOR_MACROS_SVH

// ante holds in a cycle -> cons holds in the same cycle
`define DSV_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dsv check failed");

// ante holds in a cycle -> cons holds in the next cycle
`define DSV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dsv check failed");

`endif

// File: rtl/dsv_pkg.sv
// ----------------------------------------------------------------------------
// dsv_pkg
// Types and codes shared by the decimal string parser modules.
// ----------------------------------------------------------------------------
package dsv_pkg;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // per-string control flags
  typedef struct packed {
    logic       negative;
    logic       at_first;
    logic       saw_sign;
    logic       leading_zero;
    logic [1:0] err_code;
  } flags_t;

  localparam flags_t FLAGS_RESET = '{
    negative:     1'b0,
    at_first:     1'b1,
    saw_sign:     1'b0,
    leading_zero: 1'b0,
    err_code:     ST_OK
  };

endpackage

// File: rtl/dsv_step.sv
// ----------------------------------------------------------------------------
// dsv_step
// Next-state logic for one character: sign, digit checks, multiply by ten
// with overflow check, and the result fields seen on a NUL.
// ----------------------------------------------------------------------------
module dsv_step
  import dsv_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic [7:0]            ch,
  input  flags_t                flags,
  input  logic [VALUE_BITS-2:0] accum,
  output flags_t                flags_next,
  output logic [VALUE_BITS-2:0] accum_next,
  output logic [1:0]            status,
  output logic [VALUE_BITS-1:0] value
);

  localparam int PW = VALUE_BITS + 3;
  localparam logic [PW-1:0] MAX_POS = {4'b0000, {(VALUE_BITS-1){1'b1}}};

  logic [3:0]    digit;
  logic [PW-1:0] acc_ext;
  logic [PW-1:0] prod;
  logic [VALUE_BITS-1:0] mag;

  assign digit   = 4'(ch - CH_ZERO);
  assign acc_ext = {4'b0000, accum};
  // accum * 10 + digit, as shift-add
  assign prod    = (acc_ext << 3) + (acc_ext << 1) + {{(PW-4){1'b0}}, digit};

  assign mag    = {1'b0, accum};
  assign status = flags.err_code;
  always_comb begin
    if (flags.err_code != ST_OK) begin
      value = '0;
    end else if (flags.negative) begin
      value = '0 - mag;
    end else begin
      value = mag;
    end
  end

  always_comb begin
    flags_next = flags;
    accum_next = accum;
    if (ch == CH_NUL) begin
      flags_next = FLAGS_RESET;
      accum_next = '0;
    end else if (flags.err_code == ST_OK) begin
      if (ch == CH_MINUS && flags.at_first && !flags.saw_sign) begin
        flags_next.saw_sign = 1'b1;
        flags_next.negative = 1'b1;
      end else begin
        flags_next.saw_sign = 1'b1;
        if (flags.leading_zero || ch < CH_ZERO || ch > CH_NINE) begin
          flags_next.err_code = ST_INVALID;
        end else begin
          if (flags.at_first && digit == 4'd0) begin
            flags_next.leading_zero = 1'b1;
          end
          flags_next.at_first = 1'b0;
          if (prod > MAX_POS) begin
            flags_next.err_code = ST_OVERFLOW;
          end else begin
            accum_next = prod[VALUE_BITS-2:0];
          end
        end
      end
    end
  end

endmodule

// File: rtl/decimal_string_to_int_validator.sv
// ----------------------------------------------------------------------------
// decimal_string_to_int_validator
// Parses a NUL-terminated ASCII decimal string, one character per word, into
// a signed value with an ok / invalid / overflow status.
//
//   port group   dir  tdata fields (low bit up)
//   s_axis       in   ch[7:0]
//   m_axis       out  status[1:0], value[VALUE_BITS-1:0], zero pad to bytes
//
// One character per cycle while no NUL waits on a stalled result; the input
// register and the next-state logic around accum set that figure. A result
// is registered in the cycle after its NUL leaves the input register.
// A stalled result blocks only a following NUL; other characters keep
// flowing. rst is synchronous and returns the parser to the start of a string.
// ----------------------------------------------------------------------------
`include "decimal_string_to_int_validator_macros.svh"

module decimal_string_to_int_validator
  import dsv_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,     // ch[7:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [((VALUE_BITS+2+7)/8)*8-1:0] m_tdata  // status[1:0], value
);

  logic                  in_valid;
  logic [7:0]            in_ch;
  logic                  advance;
  logic                  in_nul;

  flags_t                flags;
  flags_t                flags_next;
  logic [VALUE_BITS-2:0] accum;
  logic [VALUE_BITS-2:0] accum_next;

  logic [1:0]            res_status;
  logic [VALUE_BITS-1:0] res_value;
  logic [1:0]            out_status;
  logic [VALUE_BITS-1:0] out_value;

  assign in_nul   = (in_ch == CH_NUL);
  // a NUL word needs the result register free; other words always move on
  assign advance  = in_valid && (!in_nul || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_ch <= s_tdata;
    end
  end

  dsv_step #(
    .VALUE_BITS(VALUE_BITS)
  ) u_step (
    .ch         (in_ch),
    .flags      (flags),
    .accum      (accum),
    .flags_next (flags_next),
    .accum_next (accum_next),
    .status     (res_status),
    .value      (res_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= FLAGS_RESET;
      accum <= '0;
    end else if (advance) begin
      flags <= flags_next;
      accum <= accum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && in_nul) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_nul) begin
      out_status <= res_status;
      out_value  <= res_value;
    end
  end

  always_comb begin
    m_tdata                   = '0;
    m_tdata[1:0]              = out_status;
    m_tdata[2 +: VALUE_BITS]  = out_value;
  end

  `DSV_ASSERT_SAME(a_no_status_three, m_tvalid, out_status != 2'd3)
  `DSV_ASSERT_SAME(a_value_zero_on_error, m_tvalid && out_status != ST_OK, out_value == '0)
  `DSV_ASSERT_SAME(a_first_means_empty_accum, flags.at_first || flags.leading_zero,
                   accum == '0)
  `DSV_ASSERT_NEXT(a_error_freezes_accum,
                   advance && !in_nul && flags.err_code != ST_OK, $stable(accum))

endmodule

// File: bench/decimal_string_to_int_validator_test.sv
// ----------------------------------------------------------------------------
// decimal_string_to_int_validator_test
// Self-checking bench for the decimal string parser. Character words are fed
// from a queue by a clocked driver. A parse model runs on every accepted
// word and queues the status and value due at each NUL. A clocked monitor
// compares each result word with the oldest queued one. Stimulus starts with
// short corner strings, then random strings: mostly well-formed numbers, with
// values near the positive limit, overflows, leading zeros, stray signs and
// noise bytes. Random idling runs on both sides, and the receiver holds off
// once for a long stretch.
// ----------------------------------------------------------------------------
module decimal_string_to_int_validator_test;
  import dsv_pkg::*;

  localparam int VALUE_BITS = 32;
  localparam int TDATA_W    = ((VALUE_BITS + 2 + 7) / 8) * 8;
  localparam longint unsigned MAX_MAG = (64'd1 << (VALUE_BITS - 1)) - 1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_CHARS = 400;   // per idling phase

  typedef struct packed {
    logic [1:0]            status;
    logic [VALUE_BITS-1:0] value;
  } parsed_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [7:0]         s_tdata = 8'h00;    // ch[7:0]
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;            // status[1:0], value, zero pad

  logic [7:0] pending_chars[$];
  parsed_t    parsed_q[$];

  int chars_queued = 0;
  int chars_taken  = 0;
  int errors       = 0;
  int cycles       = 0;
  int send_idle    = 0;
  int recv_idle    = 0;
  int hold_left    = 0;
  bit hold_used    = 1'b0;

  // parse state
  longint unsigned mag = 0;
  bit minus_seen     = 1'b0;
  bit awaiting_digit = 1'b1;
  bit sign_pos_used  = 1'b0;
  bit zero_first     = 1'b0;
  logic [1:0] fault  = ST_OK;

  decimal_string_to_int_validator #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  function automatic void clear_parse();
    mag            = 0;
    minus_seen     = 1'b0;
    awaiting_digit = 1'b1;
    sign_pos_used  = 1'b0;
    zero_first     = 1'b0;
    fault          = ST_OK;
  endfunction

  // returns 1 when the character closes a string and res holds its result
  function automatic bit parse_char(input logic [7:0] c, output parsed_t res);
    longint unsigned d;
    longint unsigned v;
    res = '0;
    if (c == CH_NUL) begin
      v = minus_seen ? (64'd0 - mag) : mag;
      res.status = fault;
      res.value  = (fault == ST_OK) ? v[VALUE_BITS-1:0] : '0;
      clear_parse();
      return 1'b1;
    end
    if (fault != ST_OK) return 1'b0;
    if (c == CH_MINUS && awaiting_digit && !sign_pos_used) begin
      sign_pos_used = 1'b1;
      minus_seen    = 1'b1;
      return 1'b0;
    end
    sign_pos_used = 1'b1;
    if (zero_first || c < CH_ZERO || c > CH_NINE) begin
      fault = ST_INVALID;
      return 1'b0;
    end
    d = 64'(c - CH_ZERO);
    if (awaiting_digit && d == 0) zero_first = 1'b1;
    awaiting_digit = 1'b0;
    if (mag > (MAX_MAG - d) / 10) begin
      fault = ST_OVERFLOW;
      return 1'b0;
    end
    mag = mag * 10 + d;
    return 1'b0;
  endfunction

  function automatic logic [7:0] rand_digit(bit nonzero);
    return CH_ZERO + 8'($urandom_range(nonzero ? 1 : 0, 9));
  endfunction

  task automatic queue_char(logic [7:0] c);
    pending_chars.push_back(c);
    chars_queued++;
  endtask

  task automatic queue_text(string s);
    foreach (s[i]) queue_char(s[i]);
    queue_char(CH_NUL);
  endtask

  task automatic queue_random_string();
    logic [7:0] txt[$];
    string num;
    int kind;
    int n;
    int pos;
    kind = $urandom_range(0, 19);
    if ($urandom_range(0, 1)) txt.push_back(CH_MINUS);
    case (kind)
      0: ;  // empty or minus alone
      1, 2: begin
        // straddle the positive limit
        num = $sformatf("%0d", MAX_MAG - 7 + $urandom_range(0, 15));
        foreach (num[i]) txt.push_back(num[i]);
      end
      3: txt.push_back(CH_ZERO);
      4, 5: begin
        n = $urandom_range(11, 14);
        txt.push_back(rand_digit(1'b1));
        repeat (n - 1) txt.push_back(rand_digit(1'b0));
      end
      6: begin
        txt.push_back(CH_ZERO);
        repeat ($urandom_range(1, 12)) txt.push_back(rand_digit(1'b0));
      end
      7, 8: repeat ($urandom_range(1, 6)) txt.push_back(8'($urandom_range(1, 255)));
      9, 10: begin
        repeat ($urandom_range(1, 9)) txt.push_back(rand_digit(1'b0));
        pos = $urandom_range(0, txt.size());
        txt.insert(pos, $urandom_range(0, 1) ? CH_MINUS : 8'($urandom_range(1, 255)));
      end
      default: begin
        n = $urandom_range(1, 10);
        txt.push_back(rand_digit(1'b1));
        repeat (n - 1) txt.push_back(rand_digit(1'b0));
      end
    endcase
    foreach (txt[i]) queue_char(txt[i]);
    queue_char(CH_NUL);
  endtask

  task automatic queue_random(int count);
    int start;
    start = chars_queued;
    while (chars_queued - start < count) queue_random_string();
  endtask

  task automatic wait_drained();
    while (chars_taken != chars_queued || parsed_q.size() != 0) @(posedge clk);
  endtask

  // character driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'h00;
    end else if (!s_tvalid || s_tready) begin
      if (pending_chars.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
        s_tvalid <= 1'b1;
        s_tdata  <= pending_chars.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // one long hold-off once traffic is going; the sender keeps offering
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (!hold_used && chars_taken >= 150) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle);
  end

  // input side: run the parse model on each accepted word
  always @(posedge clk) begin
    parsed_t res;
    if (rst) begin
      clear_parse();
    end else if (s_tvalid && s_tready) begin
      chars_taken <= chars_taken + 1;
      if (parse_char(s_tdata, res)) parsed_q.push_back(res);
    end
  end

  // output side: compare each result word with the oldest expected one
  always @(posedge clk) begin
    parsed_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (parsed_q.size() == 0) begin
        $display("%0t: result with none expected, tdata %h", $time, m_tdata);
        errors++;
      end else begin
        want = parsed_q.pop_front();
        if (m_tdata[1:0] !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, m_tdata[1:0]);
          errors++;
        end
        if (m_tdata[VALUE_BITS+1:2] !== want.value) begin
          $display("%0t: value expected %0d, got %0d", $time,
                   $signed(want.value), $signed(m_tdata[VALUE_BITS+1:2]));
          errors++;
        end
        if (m_tdata[TDATA_W-1:VALUE_BITS+2] !== '0) begin
          $display("%0t: pad expected 0, got %h", $time, m_tdata[TDATA_W-1:VALUE_BITS+2]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send_idle = 24;
    recv_idle = 56;
    // corner strings
    queue_text("");
    queue_text("-");
    queue_text("-0");
    queue_text("0");
    queue_text("01");
    queue_text("1-");
    queue_text("--");
    queue_text("/:");
    queue_char(CH_NINE);
    queue_char(8'hff);
    queue_char(CH_NUL);
    queue_random(RANDOM_CHARS);
    wait_drained();

    @(negedge clk);
    send_idle = 56;
    recv_idle = 24;
    queue_random(RANDOM_CHARS);
    wait_drained();

    @(negedge clk);
    send_idle = 0;
    recv_idle = 0;
    queue_random(RANDOM_CHARS);
    wait_drained();

    repeat (20) @(posedge clk);
    if (errors == 0 && parsed_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/dsv_pkg.sv
rtl/dsv_step.sv
rtl/decimal_string_to_int_validator.sv
bench/decimal_string_to_int_validator_test.sv
